[hdl/mffn_pkg.sv]
package mffn_pkg;
    localparam logic [1:0] CODE_NONE    = 2'd0;
    localparam logic [1:0] CODE_WALL    = 2'd1;
    localparam logic [1:0] CODE_UNKNOWN = 2'd2;
    localparam logic [7:0] DIST_FREE    = 8'd255;
    localparam logic [7:0] DIST_MAX     = 8'd254;
    localparam logic [1:0] CMD_SENSE_PLAN = 2'd0;
    localparam logic [1:0] CMD_PLAN       = 2'd1;
    localparam logic [1:0] CMD_SENSE      = 2'd2;
    localparam logic [1:0] REG_GOAL_X     = 2'd0;
    localparam logic [1:0] REG_GOAL_Y     = 2'd1;
    localparam logic [1:0] REG_WALL_MASK  = 2'd2;

    typedef struct packed {
        logic [3:0] goal_x;
        logic [3:0] goal_y;
        logic [1:0] wall_mask;
    } cfg_t;
endpackage

[hdl/maze_flood_fill_navigator_core.sv]
// Maze flood-fill navigator.
// Input channel (in_valid/in_ready) takes one request per cell arrival:
// a command plus four wall sensor bits. Output channel (out_valid/out_ready)
// returns one result per request: relative turn, new heading, new cell,
// at_goal and no_path.
// Configuration writes (cfg_we, cfg_index, cfg_data) set goal cell and wall
// mask; write only while idle.
// A plan clears the distance memory (one cell per cycle), then sweeps the
// grid once per distance level until a level adds no cell: a cell not at the
// current level is skipped once its distance is read, and a cell at it visits
// its four neighbors. The neighbor is then picked and the move applied.
// One read port per memory and one neighbor unit are shared by all steps. A
// request that neither senses nor plans goes straight to the result.
// One request at a time.
// Reset: a wall-clear pass over every cell marks every wall unknown;
// in_ready stays low until it ends. Position 0,0 heading north.
// A stalled receiver holds the result; the next request waits until taken.
module maze_flood_fill_navigator_core
    import mffn_pkg::*;
#(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic       left_wall,
    input  logic       right_wall,
    input  logic       front_left_wall,
    input  logic       front_right_wall,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] turn,
    output logic [1:0] new_heading,
    output logic [3:0] new_x,
    output logic [3:0] new_y,
    output logic       at_goal,
    output logic       no_path
);
    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int AW = XW + YW;
    localparam int NCELL = GRID_X * GRID_Y;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SENSE = 4'd2;   // sequenced by sub counter
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_SWEEP = 4'd4;
    localparam logic [3:0] S_CHOOSE = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_MOVE  = 4'd7;

    cfg_t cfg;
    mffn_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    // memories: address {x, y} (index x*GRID_Y+y stored at packed address)
    logic [7:0] wall_mem [0:(1<<AW)-1];
    logic [7:0] dist_mem [0:(1<<AW)-1];

    logic [3:0]    state_reg;
    logic [XW-1:0] cur_x_reg, sx_reg;
    logic [YW-1:0] cur_y_reg, sy_reg;
    logic [1:0]    heading_reg;
    logic [1:0]    cmd_reg;
    logic [2:0]    sense_w_reg; // {left, right, front}
    logic [3:0]    sub_reg;     // micro-step
    logic [7:0]    level_reg;
    logic          changed_reg;
    logic [7:0]    cur_walls_reg;  // walls of cell under work
    logic [7:0]    rd_wall_reg, rd_dist_reg;
    logic          found_reg;
    logic [7:0]    bd_reg;
    logic [2:0]    bp_reg;
    logic [1:0]    bdir_reg;
    logic [1:0]    turn_reg;
    logic          nopath_reg;
    logic          last_cell;

    // memory port controls
    logic          w_we, d_we;
    logic [AW-1:0] w_addr, d_addr, w_waddr, d_waddr;
    logic [7:0]    w_wdata, d_wdata;

    always_ff @(posedge clk)
    begin
        if (w_we) wall_mem[w_waddr] <= w_wdata;
        rd_wall_reg <= wall_mem[w_addr];
        if (d_we) dist_mem[d_waddr] <= d_wdata;
        rd_dist_reg <= dist_mem[d_addr];
    end

    // shared neighbor unit: direction -> neighbor coordinate and in-grid
    logic [1:0]    nb_dir;
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    logic          nb_ok;
    always_comb
    begin
        nb_x = sx_reg;
        nb_y = sy_reg;
        nb_ok = 1'b0;
        case (nb_dir)
            2'd0:
            begin
                nb_ok = ({1'b0, sy_reg} + 1'b1) < (YW+1)'(GRID_Y);
                nb_y = sy_reg + 1'b1;
            end
            2'd1:
            begin
                nb_ok = ({1'b0, sx_reg} + 1'b1) < (XW+1)'(GRID_X);
                nb_x = sx_reg + 1'b1;
            end
            2'd2:
            begin
                nb_ok = sy_reg != '0;
                nb_y = sy_reg - 1'b1;
            end
            default:
            begin
                nb_ok = sx_reg != '0;
                nb_x = sx_reg - 1'b1;
            end
        endcase
    end

    function automatic logic [1:0] side(input logic [7:0] w, input logic [1:0] d);
        side = w[2*d +: 2];
    endfunction

    logic [1:0] sense_code [0:3];
    always_comb
    begin
        for (int d = 0; d < 4; d++)
        begin
            case (2'(d) - heading_reg)
                2'd0:    sense_code[d] = sense_w_reg[0] ? CODE_WALL : CODE_NONE;
                2'd1:    sense_code[d] = sense_w_reg[1] ? CODE_WALL : CODE_NONE;
                2'd3:    sense_code[d] = sense_w_reg[2] ? CODE_WALL : CODE_NONE;
                default: sense_code[d] = CODE_NONE;
            endcase
        end
    end

    logic goal_in;
    assign goal_in = ({2'b0, cfg.goal_x} < 6'(GRID_X)) && ({2'b0, cfg.goal_y} < 6'(GRID_Y));
    logic [AW-1:0] goal_addr;
    assign goal_addr = {XW'(cfg.goal_x), YW'(cfg.goal_y)};
    logic [7:0] next_level;
    assign next_level = (level_reg < DIST_MAX) ? level_reg + 8'd1 : DIST_MAX;
    assign last_cell = (32'(sx_reg) == GRID_X - 1) && (32'(sy_reg) == GRID_Y - 1);

    // even step reads neighbor dir2, the following odd step uses it
    logic [1:0] dir2;
    assign dir2 = sub_reg[2:1] - 2'd1;
    logic pass_cur;
    assign pass_cur = nb_ok && ((side(cur_walls_reg, dir2) & cfg.wall_mask) == 2'd0);
    logic unk;
    assign unk = (side(rd_wall_reg, 2'd0) == CODE_UNKNOWN) ||
                 (side(rd_wall_reg, 2'd1) == CODE_UNKNOWN) ||
                 (side(rd_wall_reg, 2'd2) == CODE_UNKNOWN) ||
                 (side(rd_wall_reg, 2'd3) == CODE_UNKNOWN);
    logic [1:0] rel;
    assign rel = dir2 - heading_reg;
    logic [2:0] prio;
    assign prio = {unk, (rel == 2'd0) ? 2'd2 : ((rel == 2'd2) ? 2'd0 : 2'd1)};
    logic pass_reg;
    logic sweep_wr;
    assign sweep_wr = sub_reg[0] && (sub_reg != 4'd1) && pass_reg &&
                      (rd_dist_reg == DIST_FREE);

    // sweep pass registered per neighbor step
    always_comb
    begin
        nb_dir = dir2;
        w_we = 1'b0; w_waddr = {sx_reg, sy_reg}; w_wdata = 8'hAA;
        w_addr = {sx_reg, sy_reg};
        d_we = 1'b0; d_waddr = {sx_reg, sy_reg}; d_wdata = DIST_FREE;
        d_addr = {sx_reg, sy_reg};
        case (state_reg)
            S_INIT: w_we = 1'b1;
            S_SENSE:
            begin
                // sub 0: read cur; sub 1: write cur; even>0: read neighbor; odd>1: write neighbor
                if (sub_reg == 4'd1)
                begin
                    w_we = 1'b1;
                    w_wdata = {sense_code[3], sense_code[2], sense_code[1], sense_code[0]};
                end
                else if (sub_reg[0] == 1'b0 && sub_reg != 4'd0)
                begin
                    nb_dir = sub_reg[2:1] - 2'd1;
                    w_addr = {nb_x, nb_y};
                end
                else if (sub_reg[0] == 1'b1)
                begin
                    nb_dir = sub_reg[2:1] - 2'd1;
                    w_we = nb_ok;
                    w_waddr = {nb_x, nb_y};
                    w_wdata = rd_wall_reg;
                    w_wdata[2*(2'(nb_dir + 2'd2)) +: 2] = sense_code[nb_dir];
                end
            end
            S_CLR:
            begin
                d_we = 1'b1;
                if (goal_in && {sx_reg, sy_reg} == goal_addr) d_wdata = 8'd0;
            end
            S_SWEEP:
            begin
                if (sub_reg != 4'd0)
                begin
                    d_addr = {nb_x, nb_y};
                    if (sub_reg[0] == 1'b1)
                    begin
                        nb_dir = sub_reg[2:1] - 2'd1;
                        d_waddr = {nb_x, nb_y};
                        d_we = sweep_wr;
                        d_wdata = next_level;
                    end
                end
            end
            S_CHOOSE:
            begin
                if (sub_reg != 4'd0 && sub_reg[0] == 1'b0)
                begin
                    w_addr = {nb_x, nb_y};
                    d_addr = {nb_x, nb_y};
                end
                else if (sub_reg[0] == 1'b1)
                    nb_dir = sub_reg[2:1] - 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sx_reg <= '0; sy_reg <= '0;
            cur_x_reg <= '0; cur_y_reg <= '0; heading_reg <= 2'd0;
            sub_reg <= '0; changed_reg <= 1'b0; level_reg <= '0;
            found_reg <= 1'b0; pass_reg <= 1'b0;
            cmd_reg <= 2'd0; sense_w_reg <= 3'd0; cur_walls_reg <= 8'd0;
            bd_reg <= 8'd0; bp_reg <= 3'd0; bdir_reg <= 2'd0;
            turn_reg <= 2'd0; nopath_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_INIT, S_CLR:
                begin
                    if (last_cell)
                    begin
                        sx_reg <= '0; sy_reg <= '0;
                        state_reg <= (state_reg == S_INIT) ? S_IDLE : S_SWEEP;
                        level_reg <= '0; changed_reg <= 1'b0; sub_reg <= '0;
                    end
                    else if (32'(sy_reg) == GRID_Y - 1)
                    begin
                        sy_reg <= '0; sx_reg <= sx_reg + 1'b1;
                    end
                    else sy_reg <= sy_reg + 1'b1;
                end
                S_IDLE:
                    if (in_valid)
                    begin
                        cmd_reg <= command;
                        sense_w_reg <= {left_wall, right_wall, front_left_wall | front_right_wall};
                        sub_reg <= '0;
                        turn_reg <= 2'd0; nopath_reg <= 1'b0;
                        if (command == CMD_PLAN)
                        begin
                            sx_reg <= '0; sy_reg <= '0; state_reg <= S_CLR;
                        end
                        else
                        begin
                            sx_reg <= cur_x_reg; sy_reg <= cur_y_reg;
                            if (command == CMD_SENSE_PLAN || command == CMD_SENSE)
                                state_reg <= S_SENSE;
                            else state_reg <= S_OUT;
                        end
                    end
                S_SENSE:
                begin
                    if (sub_reg == 4'd9)
                    begin
                        sub_reg <= '0;
                        if (cmd_reg == CMD_SENSE_PLAN)
                        begin
                            sx_reg <= '0; sy_reg <= '0; state_reg <= S_CLR;
                        end
                        else state_reg <= S_OUT;
                    end
                    else sub_reg <= sub_reg + 4'd1;
                end
                S_SWEEP:
                begin
                    // sub 0: read cell dist+walls; then per dir: even read nb, odd write
                    if (sub_reg == 4'd1)
                        cur_walls_reg <= rd_wall_reg;
                    if (sub_reg[0] == 1'b0 && sub_reg != 4'd0)
                        pass_reg <= pass_cur;
                    if ((sub_reg == 4'd1 && rd_dist_reg != level_reg) || sub_reg == 4'd9)
                    begin
                        sub_reg <= '0;
                        if (last_cell)
                        begin
                            if (level_reg < DIST_MAX) level_reg <= level_reg + 8'd1;
                            changed_reg <= 1'b0;
                            if (changed_reg || sweep_wr)
                            begin
                                sx_reg <= '0; sy_reg <= '0;
                            end
                            else
                            begin
                                sx_reg <= cur_x_reg; sy_reg <= cur_y_reg;
                                state_reg <= S_CHOOSE; found_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            if (sweep_wr) changed_reg <= 1'b1;
                            if (32'(sy_reg) == GRID_Y - 1)
                            begin
                                sy_reg <= '0; sx_reg <= sx_reg + 1'b1;
                            end
                            else sy_reg <= sy_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                        if (sweep_wr) changed_reg <= 1'b1;
                    end
                end
                S_CHOOSE:
                begin
                    if (sub_reg == 4'd1) cur_walls_reg <= rd_wall_reg;
                    if (sub_reg[0] == 1'b0 && sub_reg != 4'd0)
                        pass_reg <= (sub_reg == 4'd2) ?
                            nb_ok && ((side(rd_wall_reg, dir2) & cfg.wall_mask) == 2'd0) :
                            pass_cur;
                    if (sub_reg[0] == 1'b1 && sub_reg != 4'd1 && pass_reg &&
                        (!found_reg || rd_dist_reg < bd_reg ||
                         (rd_dist_reg == bd_reg && prio > bp_reg)))
                    begin
                        found_reg <= 1'b1; bd_reg <= rd_dist_reg; bp_reg <= prio;
                        bdir_reg <= dir2;
                    end
                    if (sub_reg == 4'd9)
                    begin
                        sub_reg <= '0;
                        sx_reg <= cur_x_reg; sy_reg <= cur_y_reg;
                        state_reg <= S_MOVE;
                    end
                    else sub_reg <= sub_reg + 4'd1;
                end
                S_MOVE:
                begin
                    // apply move
                    if (found_reg)
                    begin
                        turn_reg <= bdir_reg - heading_reg;
                        heading_reg <= bdir_reg;
                        case (bdir_reg)
                            2'd0: cur_y_reg <= cur_y_reg + 1'b1;
                            2'd1: cur_x_reg <= cur_x_reg + 1'b1;
                            2'd2: cur_y_reg <= cur_y_reg - 1'b1;
                            default: cur_x_reg <= cur_x_reg - 1'b1;
                        endcase
                    end
                    else nopath_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready    = state_reg == S_IDLE;
    assign out_valid   = state_reg == S_OUT;
    assign turn        = turn_reg;
    assign new_heading = heading_reg;
    assign new_x       = 4'(cur_x_reg);
    assign new_y       = 4'(cur_y_reg);
    assign at_goal     = ({1'b0, cfg.goal_x} == 5'(cur_x_reg)) &&
                         ({1'b0, cfg.goal_y} == 5'(cur_y_reg));
    assign no_path     = nopath_reg;
endmodule

[hdl/mffn_cfg.sv]
module mffn_cfg
    import mffn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output cfg_t       cfg
);
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x    <= 4'd7;
            cfg_reg.goal_y    <= 4'd7;
            cfg_reg.wall_mask <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GOAL_X:    cfg_reg.goal_x    <= cfg_data;
                REG_GOAL_Y:    cfg_reg.goal_y    <= cfg_data;
                REG_WALL_MASK: cfg_reg.wall_mask <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
